/* rtl/pretrigger_window_capture_top_defines.svh */
// Assertion macros for the capture block.
`ifndef PRETRIGGER_WINDOW_CAPTURE_TOP_DEFINES_SVH
`define PRETRIGGER_WINDOW_CAPTURE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked outside reset.
`define PWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define PWC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PWC_ASSERT(lbl, prop, msg)
`define PWC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/pwc_pkg.sv */
package pwc_pkg;

  localparam int unsigned DEPTH   = 131072;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned AVAIL_W = AW + 1;
  localparam int unsigned BATCH   = 46;
  localparam int unsigned BCNT_W  = $clog2(BATCH + 1);
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned CNT_W   = 18;
  localparam int unsigned TOT_W   = 32;
  localparam int unsigned START_W = 18;
  localparam int unsigned STOP_W  = 19;
  localparam int unsigned LEN_W   = STOP_W + 1;
  localparam int unsigned POS_W   = (AW + 2 > STOP_W) ? AW + 2 : STOP_W;
  localparam int unsigned WIDE_W  = TOT_W + 2;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic signed [START_W-1:0] START_RST = START_W'(-50000);
  localparam logic signed [STOP_W-1:0]  STOP_RST  = STOP_W'(50000);

  localparam logic [KIND_W-1:0] KIND_SAMPLE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ARM    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STOP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FORCE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DRAIN  = 3'd4;

  localparam logic REG_WINDOW_START = 1'b0;
  localparam logic REG_WINDOW_STOP  = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] sample_value;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] out_value;
    logic              batch_end;
    logic              end_marker;
    logic [CNT_W-1:0]  sent_count;
    logic [CNT_W-1:0]  needed_count;
  } out_word_t;

  typedef struct packed {
    logic signed [START_W-1:0] start;
    logic signed [STOP_W-1:0]  stop;
  } window_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [AW-1:0]     addr;
    logic [DATA_W-1:0] wdata;
  } ring_req_t;

endpackage

/* rtl/pwc_ring.sv */
module pwc_ring (
  input  logic                          clk_i,
  input  pwc_pkg::ring_req_t            req_i,
  output logic [pwc_pkg::DATA_W-1:0]    rdata_o
);

  logic [pwc_pkg::DATA_W-1:0] mem_q [pwc_pkg::DEPTH];
  logic [pwc_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pwc_cfg.sv */
module pwc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pwc_pkg::ADDR_W-1:0]    paddr,
  input  logic [pwc_pkg::PDATA_W-1:0]   pwdata,
  output logic [pwc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output pwc_pkg::window_t              win_o
);

  pwc_pkg::window_t win_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q.start <= pwc_pkg::START_RST;
      win_q.stop  <= pwc_pkg::STOP_RST;
    end else if (wr_en) begin
      case (paddr[2])
        pwc_pkg::REG_WINDOW_START: win_q.start <= pwdata[pwc_pkg::START_W-1:0];
        pwc_pkg::REG_WINDOW_STOP:  win_q.stop  <= pwdata[pwc_pkg::STOP_W-1:0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == pwc_pkg::REG_WINDOW_STOP) ? pwc_pkg::PDATA_W'(win_q.stop)
                                                         : pwc_pkg::PDATA_W'(win_q.start);
  assign win_o  = win_q;

endmodule

/* rtl/pwc_ctrl.sv */
`include "pretrigger_window_capture_top_defines.svh"

module pwc_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  pwc_pkg::in_word_t             in_i,
  output logic                          busy_o,
  output logic                          res_valid_o,
  output pwc_pkg::out_word_t            res_o,
  input  pwc_pkg::window_t              win_i,
  output pwc_pkg::ring_req_t            ring_req_o,
  input  logic [pwc_pkg::DATA_W-1:0]    ring_rdata_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_OUT
  } state_e;

  state_e                             state_q, state_d;
  logic [pwc_pkg::TOT_W-1:0]          total_q, total_d;
  logic [pwc_pkg::TOT_W-1:0]          since_q, since_d;
  logic [pwc_pkg::AW-1:0]             arm_idx_q, arm_idx_d;
  logic                               gathering_q, gathering_d;
  logic                               sending_q, sending_d;
  logic signed [pwc_pkg::POS_W-1:0]   cursor_q, cursor_d;
  logic signed [pwc_pkg::POS_W-1:0]   end_q, end_d;
  logic [pwc_pkg::CNT_W-1:0]          sent_q, sent_d;
  logic [pwc_pkg::BCNT_W-1:0]         bcnt_q, bcnt_d;
  logic [pwc_pkg::CNT_W-1:0]          wlen_q, wlen_d;
  logic signed [pwc_pkg::WIDE_W-1:0]  oldest_q, oldest_d;
  logic                               fin_q, fin_d;
  logic                               batch_q, batch_d;

  logic [pwc_pkg::TOT_W-1:0]          tot_n, since_n, br_total, br_since;
  logic [pwc_pkg::AVAIL_W-1:0]        avail_n, avail_c;
  logic [pwc_pkg::POS_W-1:0]          neg_c;
  logic                               ready;
  logic signed [pwc_pkg::POS_W-1:0]   br_end;
  logic signed [pwc_pkg::LEN_W-1:0]   len;
  logic signed [pwc_pkg::WIDE_W-1:0]  c_w, c_adj, c_next, end_w, since_w;
  logic                               fin;
  logic [pwc_pkg::CNT_W-1:0]          sent_inc;
  logic [pwc_pkg::BCNT_W-1:0]         bcnt_inc;
  pwc_pkg::ring_req_t                 req;

  function automatic logic [pwc_pkg::AVAIL_W-1:0] avail_of(
    input logic [pwc_pkg::TOT_W-1:0] tot
  );
    if (|tot[pwc_pkg::TOT_W-1:pwc_pkg::AW]) begin
      return pwc_pkg::AVAIL_W'(pwc_pkg::DEPTH);
    end
    return tot[pwc_pkg::AVAIL_W-1:0];
  endfunction

  always_comb begin
    tot_n   = total_q + pwc_pkg::TOT_W'(1);
    since_n = since_q + pwc_pkg::TOT_W'(1);
    avail_n = avail_of(tot_n);
    avail_c = avail_of(total_q);
    neg_c   = pwc_pkg::POS_W'(-cursor_q);

    if (end_q[pwc_pkg::POS_W-1] || end_q == '0) begin
      ready = !cursor_q[pwc_pkg::POS_W-1] || (pwc_pkg::POS_W'(avail_n) >= neg_c);
    end else begin
      ready = since_n >= pwc_pkg::TOT_W'(end_q);
    end

    br_total = (in_i.kind == pwc_pkg::KIND_SAMPLE) ? tot_n : total_q;
    br_since = (in_i.kind == pwc_pkg::KIND_SAMPLE) ? since_n : since_q;
    if (br_total == '0) begin
      br_end = cursor_q;
    end else if (!end_q[pwc_pkg::POS_W-1] && br_since < pwc_pkg::TOT_W'(end_q)) begin
      br_end = br_since[pwc_pkg::POS_W-1:0];
    end else begin
      br_end = end_q;
    end

    len = pwc_pkg::LEN_W'(win_i.stop) - pwc_pkg::LEN_W'(win_i.start);

    c_w     = pwc_pkg::WIDE_W'(cursor_q);
    end_w   = pwc_pkg::WIDE_W'(end_q);
    since_w = signed'({2'b00, since_q});
    c_adj   = c_w;
    if (c_w < oldest_q && c_w[pwc_pkg::WIDE_W-1]) begin
      c_adj = oldest_q[pwc_pkg::WIDE_W-1] ? oldest_q : '0;
    end
    c_next = c_adj + pwc_pkg::WIDE_W'(1);
    fin    = (c_adj >= end_w) || (c_adj < oldest_q) || (c_adj >= since_w);

    sent_inc = (sent_q != pwc_pkg::CNT_MAX) ? sent_q + pwc_pkg::CNT_W'(1) : sent_q;
    if (sent_q == pwc_pkg::CNT_MAX) begin
      bcnt_inc = bcnt_q;
    end else if (bcnt_q == pwc_pkg::BCNT_W'(pwc_pkg::BATCH - 1)) begin
      bcnt_inc = '0;
    end else begin
      bcnt_inc = bcnt_q + pwc_pkg::BCNT_W'(1);
    end

    state_d     = state_q;
    total_d     = total_q;
    since_d     = since_q;
    arm_idx_d   = arm_idx_q;
    gathering_d = gathering_q;
    sending_d   = sending_q;
    cursor_d    = cursor_q;
    end_d       = end_q;
    sent_d      = sent_q;
    bcnt_d      = bcnt_q;
    wlen_d      = wlen_q;
    oldest_d    = oldest_q;
    fin_d       = fin_q;
    batch_d     = batch_q;

    req.we    = 1'b0;
    req.re    = 1'b0;
    req.addr  = total_q[pwc_pkg::AW-1:0];
    req.wdata = in_i.sample_value;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (in_i.kind)
            pwc_pkg::KIND_SAMPLE: begin
              req.we  = 1'b1;
              total_d = tot_n;
              since_d = since_n;
              if (gathering_q && ready) begin
                gathering_d = 1'b0;
                sending_d   = 1'b1;
                sent_d      = '0;
                bcnt_d      = '0;
                end_d       = br_end;
              end
            end
            pwc_pkg::KIND_ARM: begin
              if (!sending_q && win_i.stop > win_i.start) begin
                wlen_d      = (len > signed'(pwc_pkg::LEN_W'(pwc_pkg::CNT_MAX))) ?
                              pwc_pkg::CNT_MAX : len[pwc_pkg::CNT_W-1:0];
                arm_idx_d   = total_q[pwc_pkg::AW-1:0];
                since_d     = '0;
                cursor_d    = pwc_pkg::POS_W'(win_i.start);
                end_d       = pwc_pkg::POS_W'(win_i.stop);
                sent_d      = '0;
                bcnt_d      = '0;
                gathering_d = 1'b1;
              end
            end
            pwc_pkg::KIND_STOP: begin
              gathering_d = 1'b0;
            end
            pwc_pkg::KIND_FORCE: begin
              if (gathering_q) begin
                gathering_d = 1'b0;
                sending_d   = 1'b1;
                sent_d      = '0;
                bcnt_d      = '0;
                end_d       = br_end;
              end
            end
            pwc_pkg::KIND_DRAIN: begin
              if (sending_q) begin
                oldest_d = since_w - signed'(pwc_pkg::WIDE_W'(avail_c));
                state_d  = ST_EVAL;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EVAL: begin
        req.addr = arm_idx_q + c_adj[pwc_pkg::AW-1:0];
        state_d  = ST_OUT;
        if (fin) begin
          cursor_d  = c_adj[pwc_pkg::POS_W-1:0];
          sending_d = 1'b0;
          fin_d     = 1'b1;
          batch_d   = 1'b0;
        end else begin
          req.re   = 1'b1;
          cursor_d = c_next[pwc_pkg::POS_W-1:0];
          sent_d   = sent_inc;
          bcnt_d   = bcnt_inc;
          fin_d    = 1'b0;
          batch_d  = (bcnt_inc == '0) || (c_next >= end_w);
        end
      end
      ST_OUT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      since_q     <= '0;
      arm_idx_q   <= '0;
      gathering_q <= 1'b0;
      sending_q   <= 1'b0;
      cursor_q    <= '0;
      end_q       <= '0;
      sent_q      <= '0;
      bcnt_q      <= '0;
      wlen_q      <= '0;
      oldest_q    <= '0;
      fin_q       <= 1'b0;
      batch_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      since_q     <= since_d;
      arm_idx_q   <= arm_idx_d;
      gathering_q <= gathering_d;
      sending_q   <= sending_d;
      cursor_q    <= cursor_d;
      end_q       <= end_d;
      sent_q      <= sent_d;
      bcnt_q      <= bcnt_d;
      wlen_q      <= wlen_d;
      oldest_q    <= oldest_d;
      fin_q       <= fin_d;
      batch_q     <= batch_d;
    end
  end

  assign ring_req_o         = req;
  assign busy_o             = (state_q != ST_IDLE);
  assign res_valid_o        = (state_q == ST_OUT);
  assign res_o.out_value    = fin_q ? '0 : ring_rdata_i;
  assign res_o.batch_end    = batch_q;
  assign res_o.end_marker   = fin_q;
  assign res_o.sent_count   = sent_q;
  assign res_o.needed_count = wlen_q;

  `PWC_ASSERT(a_drain_gives_word,
    (start_i && !busy_o && in_i.kind == pwc_pkg::KIND_DRAIN && sending_q) |-> ##2 res_valid_o,
    "drain while sending did not give a word")
  `PWC_ASSERT_ALWAYS(a_ring_single_port,
    !(req.we && req.re),
    "ring written and read in the same cycle")
  `PWC_ASSERT(a_not_gather_and_send,
    !(gathering_q && sending_q),
    "gathering and sending at once")
  `PWC_ASSERT(a_end_marker_stops,
    (res_valid_o && fin_q) |-> !sending_q,
    "end marker while still sending")

endmodule

/* rtl/pretrigger_window_capture_top.sv */
// Channel   Direction  Handshake                     Payload
// input     in         start_i, busy_o               in_i    (kind, sample_value)
// result    out        res_valid_o, one-cycle strobe res_o   (out_value .. needed_count)
// config    in/out     APB psel/penable/pwrite       window_start @0, window_stop @4
//
// Sample, arm, stop, force and idle drain words are accepted without raising busy_o.
// A drain while sending goes through accept, evaluate with ring read and result strobe;
// the registered oldest-entry bound and the registered ring read set these steps.
// busy_o is high in the evaluate and result states after a drain word accepted while sending.
// rst_ni clears all control state at once; ring contents stay undefined until written.
// Results cannot be stalled: res_o is valid only while res_valid_o is high.
module pretrigger_window_capture_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  pwc_pkg::in_word_t             in_i,
  output logic                          res_valid_o,
  output pwc_pkg::out_word_t            res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pwc_pkg::ADDR_W-1:0]    paddr,
  input  logic [pwc_pkg::PDATA_W-1:0]   pwdata,
  output logic [pwc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  pwc_pkg::window_t           win;
  pwc_pkg::ring_req_t         ring_req;
  logic [pwc_pkg::DATA_W-1:0] ring_rdata;

  pwc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .win_o   (win)
  );

  pwc_ring u_ring (
    .clk_i   (clk_i),
    .req_i   (ring_req),
    .rdata_o (ring_rdata)
  );

  pwc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .in_i         (in_i),
    .busy_o       (busy_o),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o),
    .win_i        (win),
    .ring_req_o   (ring_req),
    .ring_rdata_i (ring_rdata)
  );

endmodule

/* tb/sv/testbench.sv */
module testbench;

  localparam logic [pwc_pkg::KIND_W-1:0] KIND_MAX = {pwc_pkg::KIND_W{1'b1}};
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_WORDS  = 400;
  localparam int WIN_MIN       = -131072;
  localparam int WIN_MAX       = 131072;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  pwc_pkg::in_word_t            in_i;
  logic                         res_valid_o;
  pwc_pkg::out_word_t           res_o;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [pwc_pkg::ADDR_W-1:0]   paddr;
  logic [pwc_pkg::PDATA_W-1:0]  pwdata;
  logic [pwc_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  // capture state as the block should hold it
  logic signed [pwc_pkg::START_W-1:0] win_start;
  logic signed [pwc_pkg::STOP_W-1:0]  win_stop;
  bit [pwc_pkg::DATA_W-1:0]           ring_copy [pwc_pkg::DEPTH];
  bit [pwc_pkg::AW-1:0]               wr_ptr;
  bit [pwc_pkg::TOT_W-1:0]            rx_total;
  bit [pwc_pkg::TOT_W-1:0]            arm_mark;
  bit                                 gathering_q;
  bit                                 sending_q;
  int                                 cursor;
  int                                 end_pos;
  bit [pwc_pkg::CNT_W-1:0]            sent_cnt;
  bit [pwc_pkg::CNT_W-1:0]            win_len;

  pwc_pkg::out_word_t due_words[$];
  pwc_pkg::out_word_t due_w;
  int        err_cnt;
  int        idle_pct;
  int        random_sent;
  int        idle_steps[3] = '{0, 71, 26};

  pretrigger_window_capture_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_i        (in_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic logic [pwc_pkg::DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic longint since_arm();
    bit [pwc_pkg::TOT_W-1:0] d;
    d = rx_total - arm_mark;
    return longint'(d);
  endfunction

  function automatic longint avail_cnt();
    return (rx_total < pwc_pkg::DEPTH) ? longint'(rx_total) : longint'(pwc_pkg::DEPTH);
  endfunction

  function automatic bit window_ready();
    if (end_pos <= 0) begin
      if (cursor < 0) return avail_cnt() >= -longint'(cursor);
      return 1'b1;
    end
    return since_arm() >= longint'(end_pos);
  endfunction

  function automatic void open_readout();
    gathering_q = 1'b0;
    sending_q   = 1'b1;
    sent_cnt    = '0;
    if (rx_total == 0) begin
      end_pos = cursor;
    end else if (since_arm() < longint'(end_pos)) begin
      end_pos = int'(since_arm());
    end
  endfunction

  function automatic pwc_pkg::out_word_t drain_word();
    pwc_pkg::out_word_t   w;
    longint               since;
    longint               oldest;
    longint               c;
    bit [pwc_pkg::AW-1:0] slot;
    since  = since_arm();
    oldest = since - avail_cnt();
    c      = cursor;
    w      = '0;
    w.needed_count = win_len;
    // skip history that has been overwritten
    if (c < oldest && c < 0) c = (oldest < 0) ? oldest : 0;
    if (c >= end_pos || c < oldest || c >= since) begin
      cursor       = int'(c);
      sending_q    = 1'b0;
      w.end_marker = 1'b1;
      w.sent_count = sent_cnt;
      return w;
    end
    slot = wr_ptr - pwc_pkg::AW'(since - c);
    if (sent_cnt != pwc_pkg::CNT_MAX) sent_cnt++;
    cursor       = int'(c + 1);
    w.out_value  = ring_copy[slot];
    w.batch_end  = ((sent_cnt % pwc_pkg::BATCH) == 0) || (c + 1 >= end_pos);
    w.sent_count = sent_cnt;
    return w;
  endfunction

  function automatic void apply_word(input pwc_pkg::in_word_t w);
    int len;
    case (w.kind)
      pwc_pkg::KIND_SAMPLE: begin
        ring_copy[wr_ptr] = w.sample_value;
        wr_ptr++;
        rx_total++;
        if (gathering_q && window_ready()) open_readout();
      end
      pwc_pkg::KIND_ARM: begin
        if (!sending_q && win_stop > win_start) begin
          len         = int'(win_stop) - int'(win_start);
          win_len     = (len > int'(pwc_pkg::CNT_MAX)) ? pwc_pkg::CNT_MAX
                                                       : pwc_pkg::CNT_W'(len);
          arm_mark    = rx_total;
          cursor      = int'(win_start);
          end_pos     = int'(win_stop);
          sent_cnt    = '0;
          gathering_q = 1'b1;
        end
      end
      pwc_pkg::KIND_STOP: gathering_q = 1'b0;
      pwc_pkg::KIND_FORCE: begin
        if (gathering_q) open_readout();
      end
      pwc_pkg::KIND_DRAIN: begin
        if (sending_q) due_words.push_back(drain_word());
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input logic [pwc_pkg::KIND_W-1:0] kind,
                           input logic [pwc_pkg::DATA_W-1:0] value);
    pwc_pkg::in_word_t w;
    w.kind         = kind;
    w.sample_value = value;
    start_i <= 1'b1;
    in_i    <= w;
    do @(posedge clk_i); while (busy_o);
    apply_word(w);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic send_noise();
    send_word(pwc_pkg::KIND_W'($urandom_range(pwc_pkg::KIND_ARM, KIND_MAX)), rand64());
  endtask

  // hold off until every due word has come back
  task automatic settle();
    start_i <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window_reg(input logic reg_sel, input int value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == pwc_pkg::REG_WINDOW_START) begin
      win_start = pwc_pkg::START_W'(value);
    end else begin
      win_stop = pwc_pkg::STOP_W'(value);
    end
  endtask

  task automatic set_window(input int first, input int last);
    write_window_reg(pwc_pkg::REG_WINDOW_START, first);
    write_window_reg(pwc_pkg::REG_WINDOW_STOP, last);
  endtask

  task automatic drain_out();
    while (sending_q) send_word(pwc_pkg::KIND_DRAIN, rand64());
  endtask

  task automatic test_ignored_words();
    int k;
    idle_pct = idle_steps[0];
    send_word(pwc_pkg::KIND_DRAIN, rand64());
    for (k = pwc_pkg::KIND_DRAIN + 1; k <= KIND_MAX; k++) begin
      send_word(pwc_pkg::KIND_W'(k), rand64());
    end
    send_word(pwc_pkg::KIND_STOP, rand64());
    send_word(pwc_pkg::KIND_FORCE, rand64());
  endtask

  task automatic test_empty_force();
    idle_pct = idle_steps[1];
    send_word(pwc_pkg::KIND_ARM, rand64());
    send_word(pwc_pkg::KIND_FORCE, rand64());
    drain_out();
  endtask

  task automatic test_short_window();
    idle_pct = idle_steps[2];
    set_window(-1, 2);
    send_word(pwc_pkg::KIND_SAMPLE, '0);
    send_word(pwc_pkg::KIND_SAMPLE, '1);
    send_word(pwc_pkg::KIND_ARM, rand64());
    send_word(pwc_pkg::KIND_SAMPLE, {32{2'b01}});
    send_word(pwc_pkg::KIND_SAMPLE, {32{2'b10}});
    send_word(pwc_pkg::KIND_ARM, rand64());
    send_word(pwc_pkg::KIND_STOP, rand64());
    drain_out();
  endtask

  task automatic test_invalid_arm();
    set_window(5, 5);
    send_word(pwc_pkg::KIND_ARM, rand64());
    set_window(WIN_MAX - 1, WIN_MIN + 1);
    send_word(pwc_pkg::KIND_ARM, rand64());
  endtask

  task automatic test_widest_window();
    idle_pct = idle_steps[1];
    set_window(WIN_MIN, WIN_MAX);
    send_word(pwc_pkg::KIND_ARM, rand64());
    send_word(pwc_pkg::KIND_FORCE, rand64());
    drain_out();
  endtask

  task automatic random_capture(input int phase);
    int first;
    int last;
    int r;
    int n;
    idle_pct = idle_steps[phase % 3];
    r = $urandom_range(99);
    if (r < 8) begin
      first = $urandom_range(20);
      first = $urandom_range(1) ? WIN_MIN : first - 10;
      last  = $urandom_range(1, 60);
      last  = $urandom_range(1) ? WIN_MAX : first + last;
      set_window(first, last);
    end else if (r < 16) begin
      first = $urandom_range(100);
      first = first - 50;
      last  = $urandom_range(10);
      set_window(first, first - last);
    end else if (r < 45) begin
      first = $urandom_range(120);
      first = first - 80;
      last  = $urandom_range(1, 100);
      set_window(first, first + last);
    end
    n = $urandom_range(12);
    repeat (n) send_word(pwc_pkg::KIND_SAMPLE, rand64());
    send_word(pwc_pkg::KIND_ARM, rand64());
    random_sent += n + 1;
    n = 0;
    while (gathering_q) begin
      r = $urandom_range(99);
      if (r < 4) begin
        send_noise();
      end else if (r < 7 || n > 120) begin
        send_word(pwc_pkg::KIND_FORCE, rand64());
        random_sent++;
      end else if (r < 9) begin
        send_word(pwc_pkg::KIND_STOP, rand64());
        random_sent++;
      end else begin
        send_word(pwc_pkg::KIND_SAMPLE, rand64());
        random_sent++;
        n++;
      end
    end
    while (sending_q) begin
      r = $urandom_range(99);
      if (r < 80) begin
        send_word(pwc_pkg::KIND_DRAIN, rand64());
        random_sent++;
      end else if (r < 92) begin
        send_word(pwc_pkg::KIND_SAMPLE, rand64());
        random_sent++;
      end else begin
        send_noise();
      end
    end
    if ($urandom_range(3) == 0) settle();
  endtask

  task automatic test_random_captures();
    int phase;
    phase       = 0;
    random_sent = 0;
    while (random_sent < RANDOM_WORDS) begin
      random_capture(phase);
      phase++;
    end
  endtask

  task automatic check_field(input string name, input logic [pwc_pkg::DATA_W-1:0] want,
                             input logic [pwc_pkg::DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (due_words.size() == 0) begin
        $error("result word with nothing due: out_value %0h", res_o.out_value);
        err_cnt++;
      end else begin
        due_w = due_words.pop_front();
        check_field("out_value", due_w.out_value, res_o.out_value);
        check_field("batch_end", due_w.batch_end, res_o.batch_end);
        check_field("end_marker", due_w.end_marker, res_o.end_marker);
        check_field("sent_count", due_w.sent_count, res_o.sent_count);
        check_field("needed_count", due_w.needed_count, res_o.needed_count);
      end
    end
  end

  initial begin
    #16_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    in_i        = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    err_cnt     = 0;
    idle_pct    = 0;
    win_start   = pwc_pkg::START_RST;
    win_stop    = pwc_pkg::STOP_RST;
    wr_ptr      = '0;
    rx_total    = '0;
    arm_mark    = '0;
    gathering_q = 1'b0;
    sending_q   = 1'b0;
    cursor      = 0;
    end_pos     = 0;
    sent_cnt    = '0;
    win_len     = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_ignored_words();
    test_empty_force();
    test_short_window();
    test_invalid_arm();
    test_widest_window();
    test_random_captures();
    settle();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
